// ===== sv/ccfr_pkg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ccfr_pkg - shared types and constants of the CRC-8 checked frame receiver
// Status codes, controller command/status structs and the CRC-8 byte update.
// -----------------------------------------------------------------------------
package ccfr_pkg;

   // Result status codes
   localparam logic [2:0] ST_MID   = 3'd0;
   localparam logic [2:0] ST_GOOD  = 3'd1;
   localparam logic [2:0] ST_BAD   = 3'd2;
   localparam logic [2:0] ST_FULL  = 3'd3;
   localparam logic [2:0] ST_READ  = 3'd4;
   localparam logic [2:0] ST_EMPTY = 3'd5;

   // Request opcodes
   localparam logic OP_RECEIVE = 1'b0;
   localparam logic OP_READOUT = 1'b1;

   localparam logic [7:0] CRC_POLY = 8'h1D;
   localparam int         FW_W     = 4;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic rx_step;     // absorb one received byte and load its result
      logic empty_rsp;   // load the queue-empty result
      logic rd_start;    // open a readout of the oldest frame
      logic rd_fetch;    // issue the store read of the current readout byte
      logic rd_load;     // load the fetched byte as a result
   } ccfr_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic queue_empty;
      logic last_byte;   // readout index is on the final byte of the frame
   } ccfr_stat_type;

   // CRC-8, MSB first, one byte
   function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ===== sv/ccfr_ram.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ccfr_ram - generic simple dual-port RAM
// One write port, one read port with registered read data.
// -----------------------------------------------------------------------------
module ccfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read; read data holds while rd_en is low
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/ccfr_ctrl.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ccfr_ctrl - controller of the frame receiver
// Sequences requests, readout fetches and the result register handshake.
// -----------------------------------------------------------------------------
module ccfr_ctrl
   import ccfr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic          req_opcode,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  ccfr_stat_type stat,
   output ccfr_cmd_type  cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_ADDR = 2'd1;
   localparam logic [1:0] S_DATA = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;
   logic       req_take;
   logic       load;

   // Result register is free when empty or being taken this cycle
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign req_take  = req_valid && req_ready;

   // Decode commands and next state
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (req_opcode == OP_RECEIVE) begin
                  cmd.rx_step = 1'b1;
               end else if (stat.queue_empty) begin
                  cmd.empty_rsp = 1'b1;
               end else begin
                  cmd.rd_start = 1'b1;
                  state_in     = S_ADDR;
               end
            end
         end
         S_ADDR: begin
            cmd.rd_fetch = 1'b1;
            state_in     = S_DATA;
         end
         S_DATA: begin
            if (out_free) begin
               cmd.rd_load = 1'b1;
               state_in    = stat.last_byte ? S_IDLE : S_ADDR;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Track result register occupancy
   assign load         = cmd.rx_step || cmd.empty_rsp || cmd.rd_load;
   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== sv/ccfr_datapath.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ccfr_datapath - datapath of the frame receiver
// Frame position, running CRC, slot ring pointers, store and result register.
// -----------------------------------------------------------------------------
module ccfr_datapath
   import ccfr_pkg::*;
#(
   parameter int FRAME_BYTES = 16,
   parameter int FRAME_SLOTS = 8
) (
   input  logic            clock,
   input  logic            reset,
   input  ccfr_cmd_type    cmd,
   output ccfr_stat_type   stat,
   input  logic [7:0]      req_rx_byte,
   output logic [2:0]      rsp_status,
   output logic [7:0]      rsp_data_out,
   output logic            rsp_last,
   output logic [FW_W-1:0] rsp_frames_waiting
);

   localparam int DEPTH   = FRAME_BYTES * FRAME_SLOTS;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int SLOT_W  = $clog2(FRAME_SLOTS);
   localparam int POS_W   = $clog2(FRAME_BYTES);
   localparam int COUNT_W = $clog2(FRAME_SLOTS + 1);

   localparam logic [POS_W-1:0]   POS_LAST  = POS_W'(FRAME_BYTES - 1);
   localparam logic [SLOT_W-1:0]  SLOT_LAST = SLOT_W'(FRAME_SLOTS - 1);
   localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(FRAME_SLOTS);
   localparam logic [ADDR_W-1:0]  FB_A      = ADDR_W'(FRAME_BYTES);

   logic [SLOT_W-1:0]  write_slot_ff, write_slot_in;
   logic [SLOT_W-1:0]  read_slot_ff, read_slot_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [POS_W-1:0]   rd_idx_ff, rd_idx_in;
   logic [7:0]         crc_ff, crc_in;
   logic               ovf_ff, ovf_in;

   logic [2:0]         status_ff, status_in;
   logic [7:0]         data_ff, data_in;
   logic               last_ff, last_in;
   logic [COUNT_W-1:0] fw_ff, fw_in;

   logic               queue_full;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [ADDR_W-1:0]  rd_addr;
   logic [7:0]         rd_data;

   assign queue_full = (count_ff == COUNT_MAX);
   assign wr_en      = cmd.rx_step && !queue_full;
   assign wr_addr    = ADDR_W'(write_slot_ff) * FB_A + ADDR_W'(pos_ff);
   assign rd_addr    = ADDR_W'(read_slot_ff) * FB_A + ADDR_W'(rd_idx_ff);

   assign stat.queue_empty = (count_ff == '0);
   assign stat.last_byte   = (rd_idx_ff == POS_LAST);

   ccfr_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_rx_byte),
      .rd_en   (cmd.rd_fetch),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Advance frame state and load the result register
   always_comb begin
      write_slot_in = write_slot_ff;
      read_slot_in  = read_slot_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      rd_idx_in     = rd_idx_ff;
      crc_in        = crc_ff;
      ovf_in        = ovf_ff;
      status_in     = status_ff;
      data_in       = data_ff;
      last_in       = last_ff;
      fw_in         = fw_ff;

      if (cmd.rx_step) begin
         last_in = 1'b1;
         if (pos_ff != POS_LAST) begin
            // mid-frame byte
            ovf_in    = ovf_ff || queue_full;
            crc_in    = crc8_next(crc_ff, req_rx_byte);
            pos_in    = pos_ff + 1'b1;
            status_in = ST_MID;
            data_in   = 8'h00;
            fw_in     = count_ff;
         end else begin
            // frame complete: check the received CRC
            data_in = crc_ff;
            if (crc_ff != req_rx_byte) begin
               status_in = ST_BAD;
               fw_in     = count_ff;
            end else if (ovf_ff || queue_full) begin
               status_in = ST_FULL;
               fw_in     = count_ff;
            end else begin
               status_in     = ST_GOOD;
               write_slot_in = (write_slot_ff == SLOT_LAST) ? '0 : write_slot_ff + 1'b1;
               count_in      = count_ff + 1'b1;
               fw_in         = count_ff + 1'b1;
            end
            pos_in = '0;
            crc_in = 8'h00;
            ovf_in = 1'b0;
         end
      end

      if (cmd.empty_rsp) begin
         status_in = ST_EMPTY;
         data_in   = 8'h00;
         last_in   = 1'b1;
         fw_in     = count_ff;
      end

      if (cmd.rd_start) begin
         count_in  = count_ff - 1'b1;
         rd_idx_in = '0;
      end

      if (cmd.rd_load) begin
         status_in = ST_READ;
         data_in   = rd_data;
         last_in   = stat.last_byte;
         fw_in     = count_ff;
         if (stat.last_byte) begin
            rd_idx_in    = '0;
            read_slot_in = (read_slot_ff == SLOT_LAST) ? '0 : read_slot_ff + 1'b1;
         end else begin
            rd_idx_in = rd_idx_ff + 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         write_slot_ff <= '0;
         read_slot_ff  <= '0;
         count_ff      <= '0;
         pos_ff        <= '0;
         rd_idx_ff     <= '0;
         crc_ff        <= 8'h00;
         ovf_ff        <= 1'b0;
      end else begin
         write_slot_ff <= write_slot_in;
         read_slot_ff  <= read_slot_in;
         count_ff      <= count_in;
         pos_ff        <= pos_in;
         rd_idx_ff     <= rd_idx_in;
         crc_ff        <= crc_in;
         ovf_ff        <= ovf_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      data_ff   <= data_in;
      last_ff   <= last_in;
      fw_ff     <= fw_in;
   end

   assign rsp_status         = status_ff;
   assign rsp_data_out       = data_ff;
   assign rsp_last           = last_ff;
   assign rsp_frames_waiting = FW_W'(fw_ff);

endmodule

// ===== sv/crc8_checked_frame_receiver.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// crc8_checked_frame_receiver - CRC-8 checked frame receiver with slot ring
// Request channel (req_): opcode 0 delivers one received byte, opcode 1 asks
// for the oldest queued frame. Result channel (rsp_): status, data_out, last
// and frames_waiting, last set on the final result of each request.
// A byte gives one result: mid-frame, or at the final byte the CRC verdict
// (good and queued, CRC bad, or queue full and dropped) with the computed CRC.
// A readout gives FRAME_BYTES results; an empty queue gives one result.
// A byte or empty read is accepted when req_ready is high and its result is
// valid the next cycle; a byte follows every cycle while results are taken.
// Readout fetches each byte through an address state, then a registered store
// read, and waits in the data state while the result register is not free.
// The request channel is held off for the whole readout.
// Reset (synchronous) clears pointers, counts and the running CRC; the frame
// store is not cleared and needs no clearing pass.
// A stalled result channel holds the result register and blocks new requests.
// -----------------------------------------------------------------------------
module crc8_checked_frame_receiver
   import ccfr_pkg::*;
#(
   parameter int FRAME_BYTES = 16,
   parameter int FRAME_SLOTS = 8
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic            req_opcode,
   input  logic [7:0]      req_rx_byte,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output logic [2:0]      rsp_status,
   output logic [7:0]      rsp_data_out,
   output logic            rsp_last,
   output logic [FW_W-1:0] rsp_frames_waiting
);

   ccfr_cmd_type  cmd;
   ccfr_stat_type stat;

   ccfr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_opcode),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ccfr_datapath #(
      .FRAME_BYTES (FRAME_BYTES),
      .FRAME_SLOTS (FRAME_SLOTS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_rx_byte        (req_rx_byte),
      .rsp_status         (rsp_status),
      .rsp_data_out       (rsp_data_out),
      .rsp_last           (rsp_last),
      .rsp_frames_waiting (rsp_frames_waiting)
   );

endmodule
